@@ hdl/tpal_pkg.sv @@
package tpal_pkg;

    localparam int CW        = 32;
    localparam int TRI_DEPTH = 1024;
    localparam int SLOT_W    = $clog2(TRI_DEPTH);
    localparam int CNT_W     = 11;
    localparam int IDX_W     = 3;
    localparam int TRI_W     = 9 * CW;

    // multiplier operands, products, accumulator
    localparam int OPW   = CW + 3;
    localparam int PW    = 2 * OPW;
    localparam int ACC_W = 100;
    localparam int NW    = 2 * (CW + 1) + 1;
    localparam int SH    = OPW - 1;
    localparam int QW    = ACC_W;
    localparam int RW    = NW + 1;
    localparam int SW    = QW + 2;

    localparam logic [IDX_W-1:0] REG_XMIN  = 3'd0;
    localparam logic [IDX_W-1:0] REG_YMIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_XMAX  = 3'd2;
    localparam logic [IDX_W-1:0] REG_YMAX  = 3'd3;
    localparam logic [IDX_W-1:0] REG_COUNT = 3'd4;
    localparam logic [IDX_W-1:0] REG_INVAL = 3'd5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;
    localparam logic [1:0] ST_DEGEN   = 2'd3;

    localparam logic [1:0] K_LOAD  = 2'd0;
    localparam logic [1:0] K_SUB   = 2'd1;
    localparam logic [1:0] K_ADD   = 2'd2;
    localparam logic [1:0] K_ADDSH = 2'd3;

    localparam logic [2:0] D_NONE = 3'd0;
    localparam logic [2:0] D_S0   = 3'd1;
    localparam logic [2:0] D_S1   = 3'd2;
    localparam logic [2:0] D_S2   = 3'd3;
    localparam logic [2:0] D_NZ   = 3'd4;
    localparam logic [2:0] D_NX   = 3'd5;
    localparam logic [2:0] D_NY   = 3'd6;
    localparam logic [2:0] D_NUM  = 3'd7;

    typedef struct packed {
        logic signed [CW-1:0] z2;
        logic signed [CW-1:0] y2;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] z1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] z0;
        logic signed [CW-1:0] y0;
        logic signed [CW-1:0] x0;
    } tri_t;

    typedef struct packed {
        logic                  v;
        logic signed [OPW-1:0] a;
        logic signed [OPW-1:0] b;
        logic [1:0]            kind;
        logic [2:0]            dest;
    } mac_iss_t;

    typedef struct packed {
        logic [2:0]              neg;
        logic [2:0]              pos;
        logic signed [NW-1:0]    nz;
        logic signed [NW-1:0]    nx;
        logic signed [NW-1:0]    ny;
        logic signed [ACC_W-1:0] num;
    } mac_res_t;

    function automatic logic signed [OPW-1:0] dif(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        return OPW'(a) - OPW'(b);
    endfunction

endpackage

@@ hdl/tin_point_altitude_lookup.sv @@
// Triangle-table altitude lookup.
// Input channel (in_valid/in_stall): op=0 loads triangle (ax..cz) into slot,
// op=1 queries point (ax, ay). A load completes in the accept cycle and gives
// no result. A query gives one result item (status, altitude, hit_slot).
// Config channel (cfg_valid/cfg_ready, always ready): register index and data,
// to be written only while no query is in flight (not enforced by the block).
// Query flow: a point outside the box, or a query with nothing to scan,
// goes straight to the finish state. Inside, the scan takes each triangle
// in turn through 6 products on the single 35x35 multiplier plus pipeline
// drain; the hit triangle then has its plane normal and numerator formed,
// passes the bit-serial divider unless its normal z is zero, and is
// saturated and registered. At most 1024 triangles are scanned. One query
// is in work at a time; in_stall is high from the cycle after a query is
// accepted until its result is registered.
// The result register frees the core: the next item is accepted while a
// result still waits under out_stall; a finished query waits for the slot.
// Reset clears control state and config registers; the triangle memory is
// not cleared and a slot must be loaded before a query scans it.
module tin_point_altitude_lookup (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [9:0]         slot,
    input  logic signed [31:0] ax,
    input  logic signed [31:0] ay,
    input  logic signed [31:0] az,
    input  logic signed [31:0] bx,
    input  logic signed [31:0] by_coord,
    input  logic signed [31:0] bz,
    input  logic signed [31:0] cx,
    input  logic signed [31:0] cy,
    input  logic signed [31:0] cz,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] altitude,
    output logic [9:0]         hit_slot,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CROSS = 3'd1;
    localparam logic [2:0] S_NORM  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SAT   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam logic [3:0] CROSS_LAST = 4'd7;
    localparam logic [3:0] NORM_LAST  = 4'd11;

    logic [2:0]                         state_reg;
    logic [3:0]                         stp_reg;
    logic [tpal_pkg::CNT_W-1:0]         idx_reg;
    logic [tpal_pkg::CNT_W-1:0]         lim_reg;
    logic [tpal_pkg::CNT_W-1:0]         idx_inc;
    logic [tpal_pkg::CNT_W-1:0]         lim_new;

    logic signed [31:0]                 xmin_reg, ymin_reg, xmax_reg, ymax_reg;
    logic [tpal_pkg::CNT_W-1:0]         count_reg;
    logic signed [31:0]                 inval_reg;

    logic signed [31:0]                 qx_reg, qy_reg;
    logic                               sneg_reg;
    logic [1:0]                         res_st_reg;
    logic signed [31:0]                 res_alt_reg;
    logic [9:0]                         res_hit_reg;

    logic                               in_acc;
    logic                               outside;
    logic                               tri_hit;
    logic                               out_free;

    logic                               ram_we;
    logic                               ram_re;
    logic [tpal_pkg::SLOT_W-1:0]        ram_addr;
    logic [tpal_pkg::TRI_W-1:0]         ram_wdata;
    logic [tpal_pkg::TRI_W-1:0]         ram_rdata;
    tpal_pkg::tri_t                     t;

    tpal_pkg::mac_iss_t                 iss;
    tpal_pkg::mac_res_t                 mres;

    logic                               div_start;
    logic                               div_done;
    logic [tpal_pkg::QW-1:0]            div_num;
    logic [tpal_pkg::NW-1:0]            div_den;
    logic [tpal_pkg::QW-1:0]            div_quo;

    logic signed [tpal_pkg::OPW-1:0]    dx, dy;
    logic signed [tpal_pkg::OPW-1:0]    nxl, nxh, nyl, nyh;
    logic signed [tpal_pkg::SW-1:0]     qs;
    logic signed [tpal_pkg::SW-1:0]     zdiff;
    logic signed [31:0]                 alt_sat;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid || !out_stall;
    assign t         = tpal_pkg::tri_t'(ram_rdata);

    assign outside = (ax < xmin_reg) || (ax > xmax_reg) ||
                     (ay < ymin_reg) || (ay > ymax_reg);
    assign lim_new = (count_reg > tpal_pkg::CNT_W'(tpal_pkg::TRI_DEPTH)) ?
                     tpal_pkg::CNT_W'(tpal_pkg::TRI_DEPTH) : count_reg;
    assign idx_inc = idx_reg + 1'b1;
    assign tri_hit = (mres.neg == 3'b000) || (mres.pos == 3'b000);

    // memory port: loads write, scan reads one triangle per test
    always_comb
    begin
        ram_we    = in_acc && (op == tpal_pkg::OP_LOAD);
        ram_re    = 1'b0;
        ram_addr  = slot[tpal_pkg::SLOT_W-1:0];
        ram_wdata = {cz, cy, cx, bz, by_coord, bx, az, ay, ax};
        if (in_acc && (op == tpal_pkg::OP_QUERY))
        begin
            ram_re   = !outside && (lim_new != '0);
            ram_addr = '0;
        end
        else if (state_reg == S_CROSS && stp_reg == CROSS_LAST && !tri_hit)
        begin
            ram_re   = (idx_inc != lim_reg);
            ram_addr = idx_inc[tpal_pkg::SLOT_W-1:0];
        end
    end

    tpal_ram #(
        .W (tpal_pkg::TRI_W),
        .D (tpal_pkg::TRI_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign dx  = tpal_pkg::dif(qx_reg, t.x0);
    assign dy  = tpal_pkg::dif(qy_reg, t.y0);
    assign nxl = {1'b0, mres.nx[tpal_pkg::SH-1:0]};
    assign nxh = tpal_pkg::OPW'($signed(mres.nx[tpal_pkg::NW-1:tpal_pkg::SH]));
    assign nyl = {1'b0, mres.ny[tpal_pkg::SH-1:0]};
    assign nyh = tpal_pkg::OPW'($signed(mres.ny[tpal_pkg::NW-1:tpal_pkg::SH]));

    // product schedule
    always_comb
    begin
        iss.v    = 1'b0;
        iss.a    = '0;
        iss.b    = '0;
        iss.kind = tpal_pkg::K_LOAD;
        iss.dest = tpal_pkg::D_NONE;
        if (state_reg == S_CROSS)
        begin
            iss.v = (stp_reg <= 4'd5);
            unique case (stp_reg)
                4'd0:
                begin
                    iss.a = tpal_pkg::dif(t.x1, t.x0);
                    iss.b = tpal_pkg::dif(qy_reg, t.y1);
                end
                4'd1:
                begin
                    iss.a    = tpal_pkg::dif(qx_reg, t.x1);
                    iss.b    = tpal_pkg::dif(t.y1, t.y0);
                    iss.kind = tpal_pkg::K_SUB;
                    iss.dest = tpal_pkg::D_S0;
                end
                4'd2:
                begin
                    iss.a = tpal_pkg::dif(t.x2, t.x1);
                    iss.b = tpal_pkg::dif(qy_reg, t.y2);
                end
                4'd3:
                begin
                    iss.a    = tpal_pkg::dif(qx_reg, t.x2);
                    iss.b    = tpal_pkg::dif(t.y2, t.y1);
                    iss.kind = tpal_pkg::K_SUB;
                    iss.dest = tpal_pkg::D_S1;
                end
                4'd4:
                begin
                    iss.a = tpal_pkg::dif(t.x0, t.x2);
                    iss.b = tpal_pkg::dif(qy_reg, t.y0);
                end
                4'd5:
                begin
                    iss.a    = dx;
                    iss.b    = tpal_pkg::dif(t.y0, t.y2);
                    iss.kind = tpal_pkg::K_SUB;
                    iss.dest = tpal_pkg::D_S2;
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_NORM)
        begin
            iss.v = (stp_reg <= 4'd9);
            unique case (stp_reg)
                4'd0:
                begin
                    iss.a = tpal_pkg::dif(t.x1, t.x0);
                    iss.b = tpal_pkg::dif(t.y2, t.y0);
                end
                4'd1:
                begin
                    iss.a    = tpal_pkg::dif(t.y1, t.y0);
                    iss.b    = tpal_pkg::dif(t.x2, t.x0);
                    iss.kind = tpal_pkg::K_SUB;
                    iss.dest = tpal_pkg::D_NZ;
                end
                4'd2:
                begin
                    iss.a = tpal_pkg::dif(t.y1, t.y0);
                    iss.b = tpal_pkg::dif(t.z2, t.z0);
                end
                4'd3:
                begin
                    iss.a    = tpal_pkg::dif(t.z1, t.z0);
                    iss.b    = tpal_pkg::dif(t.y2, t.y0);
                    iss.kind = tpal_pkg::K_SUB;
                    iss.dest = tpal_pkg::D_NX;
                end
                4'd4:
                begin
                    iss.a = tpal_pkg::dif(t.z1, t.z0);
                    iss.b = tpal_pkg::dif(t.x2, t.x0);
                end
                4'd5:
                begin
                    iss.a    = tpal_pkg::dif(t.x1, t.x0);
                    iss.b    = tpal_pkg::dif(t.z2, t.z0);
                    iss.kind = tpal_pkg::K_SUB;
                    iss.dest = tpal_pkg::D_NY;
                end
                4'd6:
                begin
                    iss.a = nxl;
                    iss.b = dx;
                end
                4'd7:
                begin
                    iss.a    = nxh;
                    iss.b    = dx;
                    iss.kind = tpal_pkg::K_ADDSH;
                end
                4'd8:
                begin
                    iss.a    = nyl;
                    iss.b    = dy;
                    iss.kind = tpal_pkg::K_ADD;
                end
                4'd9:
                begin
                    iss.a    = nyh;
                    iss.b    = dy;
                    iss.kind = tpal_pkg::K_ADDSH;
                    iss.dest = tpal_pkg::D_NUM;
                end
                default:
                begin
                end
            endcase
        end
    end

    tpal_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .iss   (iss),
        .res   (mres)
    );

    assign div_start = (state_reg == S_NORM) && (stp_reg == NORM_LAST) && (mres.nz != '0);
    assign div_num   = mres.num[tpal_pkg::ACC_W-1] ? (-mres.num) : mres.num;
    assign div_den   = mres.nz[tpal_pkg::NW-1] ? (-mres.nz) : mres.nz;

    tpal_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign qs    = sneg_reg ? -tpal_pkg::SW'(div_quo) : tpal_pkg::SW'(div_quo);
    assign zdiff = tpal_pkg::SW'(t.z0) - qs;

    always_comb
    begin
        priority if (zdiff > tpal_pkg::SW'(32'sh7fffffff))
        begin
            alt_sat = 32'sh7fffffff;
        end
        else if (zdiff < -tpal_pkg::SW'(33'sh080000000))
        begin
            alt_sat = 32'sh80000000;
        end
        else
        begin
            alt_sat = zdiff[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xmin_reg  <= '0;
            ymin_reg  <= '0;
            xmax_reg  <= '0;
            ymax_reg  <= '0;
            count_reg <= '0;
            inval_reg <= 32'sh80000000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tpal_pkg::REG_XMIN:  xmin_reg  <= cfg_data;
                tpal_pkg::REG_YMIN:  ymin_reg  <= cfg_data;
                tpal_pkg::REG_XMAX:  xmax_reg  <= cfg_data;
                tpal_pkg::REG_YMAX:  ymax_reg  <= cfg_data;
                tpal_pkg::REG_COUNT: count_reg <= cfg_data[tpal_pkg::CNT_W-1:0];
                tpal_pkg::REG_INVAL: inval_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stp_reg   <= '0;
            idx_reg   <= '0;
            lim_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall && (state_reg != S_FIN))
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && (op == tpal_pkg::OP_QUERY))
                    begin
                        idx_reg <= '0;
                        lim_reg <= lim_new;
                        stp_reg <= '0;
                        if (outside || lim_new == '0)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_CROSS;
                        end
                    end
                end
                S_CROSS:
                begin
                    if (stp_reg == CROSS_LAST)
                    begin
                        stp_reg <= '0;
                        if (tri_hit)
                        begin
                            state_reg <= S_NORM;
                        end
                        else
                        begin
                            idx_reg <= idx_inc;
                            if (idx_inc == lim_reg)
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                    end
                    else
                    begin
                        stp_reg <= stp_reg + 1'b1;
                    end
                end
                S_NORM:
                begin
                    if (stp_reg == NORM_LAST)
                    begin
                        stp_reg   <= '0;
                        state_reg <= (mres.nz == '0) ? S_FIN : S_DIV;
                    end
                    else
                    begin
                        stp_reg <= stp_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SAT;
                    end
                end
                S_SAT:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // query payload and pending result
    always_ff @(posedge clk)
    begin
        if (in_acc && (op == tpal_pkg::OP_QUERY))
        begin
            qx_reg      <= ax;
            qy_reg      <= ay;
            res_alt_reg <= inval_reg;
            res_hit_reg <= '0;
            res_st_reg  <= outside ? tpal_pkg::ST_OUTSIDE : tpal_pkg::ST_NONE;
        end
        if (state_reg == S_NORM && stp_reg == NORM_LAST && mres.nz == '0)
        begin
            res_st_reg <= tpal_pkg::ST_DEGEN;
        end
        if (div_start)
        begin
            sneg_reg <= mres.num[tpal_pkg::ACC_W-1] ^ mres.nz[tpal_pkg::NW-1];
        end
        if (state_reg == S_SAT)
        begin
            res_st_reg  <= tpal_pkg::ST_FOUND;
            res_alt_reg <= alt_sat;
            res_hit_reg <= idx_reg[9:0];
        end
        if (state_reg == S_FIN && out_free)
        begin
            status   <= res_st_reg;
            altitude <= res_alt_reg;
            hit_slot <= res_hit_reg;
        end
    end

endmodule

@@ hdl/tpal_ram.sv @@
module tpal_ram #(
    parameter int W = 32,
    parameter int D = 1024
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic                 re,
    input  logic [$clog2(D)-1:0] addr,
    input  logic [W-1:0]         wdata,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ hdl/tpal_mac.sv @@
// one product per cycle, accumulated the cycle after; results latched by dest tag
module tpal_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  tpal_pkg::mac_iss_t  iss,
    output tpal_pkg::mac_res_t  res
);

    logic                                 v_reg;
    logic [1:0]                           kind_reg;
    logic [2:0]                           dest_reg;
    logic signed [tpal_pkg::PW-1:0]       prod_reg;
    logic signed [tpal_pkg::ACC_W-1:0]    acc_reg;
    logic signed [tpal_pkg::ACC_W-1:0]    acc_next;
    logic signed [tpal_pkg::ACC_W-1:0]    pext;
    logic                                 nneg;
    logic                                 npos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= iss.v;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= iss.a * iss.b;
        kind_reg <= iss.kind;
        dest_reg <= iss.dest;
    end

    assign pext = tpal_pkg::ACC_W'(prod_reg);

    always_comb
    begin
        unique case (kind_reg)
            tpal_pkg::K_LOAD:  acc_next = pext;
            tpal_pkg::K_SUB:   acc_next = acc_reg - pext;
            tpal_pkg::K_ADD:   acc_next = acc_reg + pext;
            tpal_pkg::K_ADDSH: acc_next = acc_reg + (pext <<< tpal_pkg::SH);
            default:           acc_next = pext;
        endcase
    end

    assign nneg = acc_next[tpal_pkg::ACC_W-1];
    assign npos = !nneg && (acc_next != '0);

    always_ff @(posedge clk)
    begin
        if (v_reg)
        begin
            acc_reg <= acc_next;
            unique case (dest_reg)
                tpal_pkg::D_S0:
                begin
                    res.neg[0] <= nneg;
                    res.pos[0] <= npos;
                end
                tpal_pkg::D_S1:
                begin
                    res.neg[1] <= nneg;
                    res.pos[1] <= npos;
                end
                tpal_pkg::D_S2:
                begin
                    res.neg[2] <= nneg;
                    res.pos[2] <= npos;
                end
                tpal_pkg::D_NZ:  res.nz  <= acc_next[tpal_pkg::NW-1:0];
                tpal_pkg::D_NX:  res.nx  <= acc_next[tpal_pkg::NW-1:0];
                tpal_pkg::D_NY:  res.ny  <= acc_next[tpal_pkg::NW-1:0];
                tpal_pkg::D_NUM: res.num <= acc_next;
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ hdl/tpal_div.sv @@
// restoring divider, one quotient bit per cycle
module tpal_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [tpal_pkg::QW-1:0]  num,
    input  logic [tpal_pkg::NW-1:0]  den,
    output logic                     done,
    output logic [tpal_pkg::QW-1:0]  quo
);

    localparam int CNTW = $clog2(tpal_pkg::QW + 1);

    logic [CNTW-1:0]           cnt_reg;
    logic                      busy_reg;
    logic [tpal_pkg::RW-1:0]   rem_reg;
    logic [tpal_pkg::QW-1:0]   quo_reg;
    logic [tpal_pkg::NW-1:0]   den_reg;
    logic [tpal_pkg::RW-1:0]   rem_sh;
    logic                      ge;

    assign rem_sh = {rem_reg[tpal_pkg::RW-2:0], quo_reg[tpal_pkg::QW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= !start && busy_reg && (cnt_reg == CNTW'(tpal_pkg::QW - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(tpal_pkg::QW - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[tpal_pkg::QW-2:0], ge};
        end
    end

    assign quo = quo_reg;

endmodule

@@ hdl/tpal_chk.sv @@
module tpal_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               op,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic [9:0]         hit_slot,
    input logic               cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(hit_slot))
        else $error("result changed while stalled");

    a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != tpal_pkg::ST_FOUND) |-> hit_slot == '0)
        else $error("hit_slot nonzero without a hit");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == tpal_pkg::OP_QUERY) |=> in_stall)
        else $error("query accepted without taking the core");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == tpal_pkg::OP_LOAD) |=> !in_stall)
        else $error("load held the core");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");

endmodule

bind tin_point_altitude_lookup tpal_chk u_chk (.*);
